### hw/rtl/irwd_pkg.sv
// ----------------------------------------------------------------------------
// irwd_pkg
// shared widths, register codes and lane types of the ir wall detector
// ----------------------------------------------------------------------------
package irwd_pkg;

    localparam int LANES      = 4;
    localparam int SAMPLE_W   = 12;
    localparam int CNT_W      = 4;
    localparam int RING_DEPTH = 3;
    localparam int PTR_W      = $clog2(RING_DEPTH);
    localparam int IDX_W      = 3;

    // lane order
    localparam int LANE_FL = 0;
    localparam int LANE_FR = 1;
    localparam int LANE_SL = 2;
    localparam int LANE_SR = 3;

    // stream widths, padded to whole bytes
    localparam int IN_TDATA_W  = ((2 * LANES * SAMPLE_W + 7) / 8) * 8;
    localparam int OUT_BITS    = LANES * SAMPLE_W + 3;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    // register indexes
    localparam logic [IDX_W-1:0] CFG_THR_FL  = 3'd0;
    localparam logic [IDX_W-1:0] CFG_THR_FR  = 3'd1;
    localparam logic [IDX_W-1:0] CFG_THR_SL  = 3'd2;
    localparam logic [IDX_W-1:0] CFG_THR_SR  = 3'd3;
    localparam logic [IDX_W-1:0] CFG_CONFIRM = 3'd4;
    localparam logic [IDX_W-1:0] CFG_RELEASE = 3'd5;

    localparam logic [CNT_W-1:0] CONFIRM_RST = 4'd4;
    localparam logic [CNT_W-1:0] RELEASE_RST = 4'd6;

    typedef logic [SAMPLE_W-1:0] t_sample;
    typedef logic [CNT_W-1:0]    t_count;

    typedef struct packed {
        logic   en;
        logic   restart;
        t_count conf_cnt;
        t_count rel_cnt;
    } t_lane_ctrl;

    typedef struct packed {
        t_sample median;
        logic    wall;
    } t_lane_res;

endpackage

### hw/rtl/irwd_lane.sv
// ----------------------------------------------------------------------------
// irwd_lane
// one sensor: ambient subtract, median-of-three ring, hysteresis counter
// ----------------------------------------------------------------------------
module irwd_lane (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  irwd_pkg::t_lane_ctrl i_ctrl,
    input  irwd_pkg::t_sample   i_lit,
    input  irwd_pkg::t_sample   i_dark,
    input  irwd_pkg::t_sample   i_threshold,
    output irwd_pkg::t_lane_res o_res
);
    import irwd_pkg::*;

    t_sample            r_ring [RING_DEPTH];
    t_sample            n_ring [RING_DEPTH];
    logic [PTR_W-1:0]   r_ptr, n_ptr;
    logic               r_seeded;
    t_count             r_cnt, n_cnt;
    logic               r_wall, n_wall;

    logic [SAMPLE_W:0]  sub;
    t_sample            diff;
    logic [PTR_W-1:0]   ptr_eff;
    t_count             cnt_base;
    logic               wall_base;
    logic               seen;
    t_sample            lo, hi;

    always_comb begin
        sub  = {1'b0, i_lit} - {1'b0, i_dark};
        diff = sub[SAMPLE_W] ? '0 : sub[SAMPLE_W-1:0];

        // pointer past the last entry counts as entry zero
        ptr_eff = (r_ptr >= PTR_W'(RING_DEPTH)) ? '0 : r_ptr;
        n_ptr   = r_ptr;
        for (int k = 0; k < RING_DEPTH; k++) begin
            n_ring[k] = r_ring[k];
        end
        if (diff != '0) begin
            for (int k = 0; k < RING_DEPTH; k++) begin
                if (!r_seeded || ptr_eff == PTR_W'(k)) begin
                    n_ring[k] = diff;
                end
            end
            n_ptr = (ptr_eff == PTR_W'(RING_DEPTH - 1)) ? '0 : ptr_eff + 1'b1;
        end

        // median of the updated ring
        lo = (n_ring[0] < n_ring[1]) ? n_ring[0] : n_ring[1];
        hi = (n_ring[0] < n_ring[1]) ? n_ring[1] : n_ring[0];
        if (n_ring[2] <= lo) begin
            o_res.median = lo;
        end else if (n_ring[2] >= hi) begin
            o_res.median = hi;
        end else begin
            o_res.median = n_ring[2];
        end

        cnt_base  = i_ctrl.restart ? '0 : r_cnt;
        wall_base = i_ctrl.restart ? 1'b0 : r_wall;
        seen      = diff > i_threshold;
        if (seen) begin
            n_cnt = (cnt_base < i_ctrl.rel_cnt) ? cnt_base + 1'b1 : cnt_base;
        end else begin
            n_cnt = (cnt_base != '0) ? cnt_base - 1'b1 : cnt_base;
        end
        if (!wall_base) begin
            n_wall = n_cnt >= i_ctrl.conf_cnt;
        end else begin
            n_wall = n_cnt != '0;
        end
        o_res.wall = n_wall;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < RING_DEPTH; k++) begin
                r_ring[k] <= '0;
            end
            r_ptr    <= '0;
            r_seeded <= 1'b0;
            r_cnt    <= '0;
            r_wall   <= 1'b0;
        end else if (i_ctrl.en) begin
            for (int k = 0; k < RING_DEPTH; k++) begin
                r_ring[k] <= n_ring[k];
            end
            r_ptr  <= n_ptr;
            r_cnt  <= n_cnt;
            r_wall <= n_wall;
            if (diff != '0) begin
                r_seeded <= 1'b1;
            end
        end
    end

endmodule

### hw/rtl/irwd_merge.sv
// ----------------------------------------------------------------------------
// irwd_merge
// combines lane results into one result request, output register plus skid
// ----------------------------------------------------------------------------
module irwd_merge (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    input  irwd_pkg::t_lane_res [irwd_pkg::LANES-1:0] i_res,
    output logic                                 o_skid_full,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [irwd_pkg::OUT_TDATA_W-1:0]     o_data
);
    import irwd_pkg::*;

    logic [OUT_TDATA_W-1:0] packed_res;
    logic [OUT_TDATA_W-1:0] r_out, r_skid;
    logic                   r_out_valid, r_skid_valid;
    logic                   take;

    always_comb begin
        packed_res = '0;
        for (int k = 0; k < LANES; k++) begin
            packed_res[k*SAMPLE_W +: SAMPLE_W] = i_res[k].median;
        end
        packed_res[LANES*SAMPLE_W]     = i_res[LANE_SL].wall;
        packed_res[LANES*SAMPLE_W + 1] = i_res[LANE_SR].wall;
        packed_res[LANES*SAMPLE_W + 2] = i_res[LANE_FL].wall | i_res[LANE_FR].wall;
    end

    assign take = r_out_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            // no new request is taken while the skid holds one
            if (take) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (i_valid) begin
            if (!r_out_valid || take) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (take) begin
                r_out <= r_skid;
            end
        end else if (i_valid) begin
            if (!r_out_valid || take) begin
                r_out <= packed_res;
            end else begin
                r_skid <= packed_res;
            end
        end
    end

    assign o_skid_full = r_skid_valid;
    assign o_valid     = r_out_valid;
    assign o_data      = r_out;

endmodule

### hw/rtl/ir_wall_detect_hysteresis_core.sv
// ----------------------------------------------------------------------------
// ir_wall_detect_hysteresis_core
// four infrared wall sensors: ambient subtract, median filter, hysteresis flags
// each accepted request's result is registered in the output or the skid register
// throughput: one request per cycle with the skid empty, via a single lane stage
// a stalled output keeps taking requests until the two-entry output buffer fills
// reset: synchronous active low; rings, counters, flags and registers to defaults
// ----------------------------------------------------------------------------
module ir_wall_detect_hysteresis_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // lit_fl, dark_fl, lit_fr, dark_fr, lit_sl, dark_sl, lit_sr, dark_sr
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic [irwd_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    // restart_walls
    input  logic [0:0]                          i_s_axis_tuser,
    // median_fl, median_fr, median_sl, median_sr, wall_left, wall_right,
    // wall_front, zero pad
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    output logic [irwd_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata,
    // register write channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [irwd_pkg::IDX_W-1:0]          i_cfg_index,
    input  logic [irwd_pkg::SAMPLE_W-1:0]       i_cfg_data
);
    import irwd_pkg::*;

    // configuration registers
    t_sample    r_thr [LANES];
    t_count     r_confirm;
    t_count     r_release;

    logic       accept;
    logic       skid_full;
    t_lane_ctrl lane_ctrl;
    t_lane_res [LANES-1:0] lane_res;

    // registers always take a write
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LANES; k++) begin
                r_thr[k] <= '0;
            end
            r_confirm <= CONFIRM_RST;
            r_release <= RELEASE_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index) inside
                CFG_THR_FL, CFG_THR_FR, CFG_THR_SL, CFG_THR_SR: begin
                    r_thr[i_cfg_index[1:0]] <= i_cfg_data;
                end
                CFG_CONFIRM: begin
                    r_confirm <= i_cfg_data[CNT_W-1:0];
                end
                CFG_RELEASE: begin
                    r_release <= i_cfg_data[CNT_W-1:0];
                end
                default: begin
                    // unused index, write dropped
                end
            endcase
        end
    end

    // input side stalls only when both output entries are occupied
    assign o_s_axis_tready = !skid_full;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        lane_ctrl.en       = accept;
        lane_ctrl.restart  = i_s_axis_tuser[0];
        lane_ctrl.conf_cnt = r_confirm;
        lane_ctrl.rel_cnt  = r_release;
    end

    // one lane per sensor, all updated in the accepting cycle
    for (genvar g = 0; g < LANES; g++) begin : g_lane
        irwd_lane u_lane (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctrl      (lane_ctrl),
            .i_lit       (i_s_axis_tdata[(2*g)*SAMPLE_W +: SAMPLE_W]),
            .i_dark      (i_s_axis_tdata[(2*g+1)*SAMPLE_W +: SAMPLE_W]),
            .i_threshold (r_thr[g]),
            .o_res       (lane_res[g])
        );
    end

    // pack the lane findings, front flag is the or of both front lanes
    irwd_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (accept),
        .i_res       (lane_res),
        .o_skid_full (skid_full),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_data      (o_m_axis_tdata)
    );

endmodule

### hw/rtl/irwd_checker.sv
// ----------------------------------------------------------------------------
// irwd_checker
// port-level checks of the wall detector's request flow
// ----------------------------------------------------------------------------
module irwd_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_s_axis_tvalid,
    input logic                             o_s_axis_tready,
    input logic [irwd_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    input logic [0:0]                       i_s_axis_tuser,
    input logic                             o_m_axis_tvalid,
    input logic                             i_m_axis_tready,
    input logic [irwd_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    input logic                             i_cfg_valid,
    input logic                             o_cfg_ready,
    input logic [irwd_pkg::IDX_W-1:0]       i_cfg_index,
    input logic [irwd_pkg::SAMPLE_W-1:0]    i_cfg_data
);
    import irwd_pkg::*;

    // a held result keeps its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("output changed while stalled");

    // an accepted request always yields a pending result next cycle
    a_accept_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> o_m_axis_tvalid)
        else $error("accepted request produced no result");

    // input stalls only with a result waiting
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> o_m_axis_tvalid)
        else $error("input stalled with empty output");

    // nothing pending right after reset
    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> !o_m_axis_tvalid && o_s_axis_tready)
        else $error("result pending after reset");

    // unused inputs of this check set
    logic unused_ok;
    assign unused_ok = ^{i_s_axis_tdata, i_s_axis_tuser, i_cfg_valid, o_cfg_ready,
                         i_cfg_index, i_cfg_data};

endmodule

bind ir_wall_detect_hysteresis_core irwd_checker u_irwd_checker (.*);
